FILE: rtl/s1_gradient_score_macros.svh
// Assertion shorthands used by the back end (s1gs_back).
`ifndef S1_GRADIENT_SCORE_MACROS_SVH
`define S1_GRADIENT_SCORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define S1GS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("s1_gradient_score: check failed");

// Consequent must hold in the cycle after the antecedent.
`define S1GS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("s1_gradient_score: check failed");

`endif

FILE: rtl/s1gs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package s1gs_pkg;

	localparam int SCORE_W     = 16;
	localparam int CFG_ADDR_W  = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SCORE_W-1:0]    SCORE_CAP         = 16'd51200;
	localparam logic [CFG_DATA_W-1:0] WORST_SCORE_RESET = 16'd51200;

	localparam logic [CFG_ADDR_W-1:0] REG_CHECK_NANS  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WORST_SCORE = 1'd1;

	typedef struct packed {
		logic signed [15:0] ref_value;
		logic signed [15:0] eval_value;
		logic               ref_missing;
		logic               eval_missing;
		logic               last_pair;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               score_missing;
	} out_item_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_CHECK,
		BS_DIV,
		BS_EMIT
	} back_state_t;

endpackage

`default_nettype wire

FILE: rtl/s1_gradient_score.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data   (in_item_t)
// out     | output    | out_valid / out_ready | out_data  (out_item_t)
// cfg     | input     | cfg_we                | cfg_addr, cfg_wdata
//
// The front takes one sample pair per cycle while not stalled, through a two-stage pipeline (magnitudes,
// then saturating accumulation); out_valid rises once the last pair of a field has passed one front
// stage, the queue write, then load, check, 16 divider steps and emit in the back.
// A missing, empty or clamped field skips the divider and goes straight from check to emit.
// Two finished fields may wait in the queue; the front stalls only on a last pair while it is full.
// Reset clears all control state and the sums at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module s1_gradient_score import s1gs_pkg::*; #(
	parameter int MAX_PAIRS   = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int ACC_W = $clog2(MAX_PAIRS) + SAMPLE_BITS;
	localparam int JOB_W = 2 * ACC_W + 1;

	logic                  check_nans_q;
	logic [CFG_DATA_W-1:0] worst_score_q;

	logic             q_full, q_push, q_missing, q_pop, q_not_empty;
	logic [ACC_W-1:0] q_diff, q_mag;
	logic [JOB_W-1:0] q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_nans_q  <= 1'b0;
			worst_score_q <= WORST_SCORE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CHECK_NANS:  check_nans_q  <= cfg_wdata[0];
				REG_WORST_SCORE: worst_score_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	s1gs_front #(
		.MAX_PAIRS   (MAX_PAIRS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.ACC_W       (ACC_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.check_nans (check_nans_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_diff     (q_diff),
		.q_mag      (q_mag),
		.q_missing  (q_missing)
	);

	s1gs_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({q_missing, q_mag, q_diff}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	s1gs_back #(
		.ACC_W (ACC_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.worst_score (worst_score_q),
		.job_valid   (q_not_empty),
		.job_diff    (q_head[ACC_W-1:0]),
		.job_mag     (q_head[2*ACC_W-1:ACC_W]),
		.job_missing (q_head[JOB_W-1]),
		.job_pop     (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

FILE: rtl/s1gs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module s1gs_front import s1gs_pkg::*; #(
	parameter int MAX_PAIRS   = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_W       = $clog2(MAX_PAIRS) + SAMPLE_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             check_nans,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_data,
	input  wire logic             q_full,
	output logic                  q_push,
	output logic [ACC_W-1:0]      q_diff,
	output logic [ACC_W-1:0]      q_mag,
	output logic                  q_missing
);

	localparam int S = SAMPLE_BITS;
	localparam logic [ACC_W-1:0] DIFF_LIMIT = ACC_W'(MAX_PAIRS) * ACC_W'({S{1'b1}});
	localparam logic [ACC_W-1:0] MAG_LIMIT  = ACC_W'(MAX_PAIRS) << (S - 1);

	// stage 1: magnitudes and classification
	logic [S-1:0] r_raw, e_raw, r_abs, e_abs, d_c, m_c;
	logic         r_neg, e_neg, pair_missing;

	logic         valid_s1, last_s1, miss_s1;
	logic [S-1:0] diff_s1, mag_s1;

	logic             advance;
	logic [ACC_W-1:0] diff_acc_q, mag_acc_q;
	logic             miss_acc_q;
	logic [ACC_W:0]   diff_wide, mag_wide;
	logic [ACC_W-1:0] diff_next, mag_next;

	always_comb begin
		r_raw = S'($unsigned(in_data.ref_value));
		e_raw = S'($unsigned(in_data.eval_value));
		r_neg = r_raw[S-1];
		e_neg = e_raw[S-1];
		r_abs = r_neg ? S'(~r_raw + S'(1)) : r_raw;
		e_abs = e_neg ? S'(~e_raw + S'(1)) : e_raw;
		if (r_neg == e_neg) begin
			d_c = (r_abs > e_abs) ? S'(r_abs - e_abs) : S'(e_abs - r_abs);
		end else begin
			d_c = S'(r_abs + e_abs);
		end
		m_c = (r_abs > e_abs) ? r_abs : e_abs;
		pair_missing = in_data.ref_missing | in_data.eval_missing;
	end

	assign advance  = valid_s1 && !(last_s1 && q_full);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			last_s1 <= in_data.last_pair;
			miss_s1 <= pair_missing && !check_nans;
			diff_s1 <= pair_missing ? '0 : d_c;
			mag_s1  <= pair_missing ? '0 : m_c;
		end
	end

	// stage 2: saturating accumulation
	always_comb begin
		diff_wide = {1'b0, diff_acc_q} + (ACC_W+1)'(diff_s1);
		mag_wide  = {1'b0, mag_acc_q} + (ACC_W+1)'(mag_s1);
		diff_next = (diff_wide > {1'b0, DIFF_LIMIT}) ? DIFF_LIMIT : diff_wide[ACC_W-1:0];
		mag_next  = (mag_wide > {1'b0, MAG_LIMIT}) ? MAG_LIMIT : mag_wide[ACC_W-1:0];
	end

	assign q_push    = advance && last_s1;
	assign q_diff    = diff_next;
	assign q_mag     = mag_next;
	assign q_missing = miss_acc_q | miss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_acc_q <= '0;
			mag_acc_q  <= '0;
			miss_acc_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				diff_acc_q <= '0;
				mag_acc_q  <= '0;
				miss_acc_q <= 1'b0;
			end else begin
				diff_acc_q <= diff_next;
				mag_acc_q  <= mag_next;
				miss_acc_q <= miss_acc_q | miss_s1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/s1gs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module s1gs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/s1gs_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "s1_gradient_score_macros.svh"

module s1gs_back import s1gs_pkg::*; #(
	parameter int ACC_W = 28
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [CFG_DATA_W-1:0] worst_score,
	input  wire logic                  job_valid,
	input  wire logic [ACC_W-1:0]      job_diff,
	input  wire logic [ACC_W-1:0]      job_mag,
	input  wire logic                  job_missing,
	output logic                       job_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data
);

	localparam int NW = ACC_W + 15;
	localparam int HW = NW - SCORE_W;
	localparam int CW = $clog2(SCORE_W);

	back_state_t state_q, state_d;

	logic [NW-1:0]      num_c;
	logic [HW-1:0]      hi_q;
	logic [SCORE_W-1:0] lo_q, quo_q, quo_next;
	logic [ACC_W-1:0]   mag_q, rem_q;
	logic               miss_q;
	logic [CW-1:0]      cnt_q;
	logic [ACC_W:0]     trial, trial_sub;
	logic               take;
	logic [SCORE_W-1:0] res_score_q;
	logic               res_miss_q;
	logic               out_load;
	logic               out_valid_q;
	out_item_t          out_data_q;

	// 25600 * d = (64 + 32 + 4) * 256 * d
	assign num_c = (NW'(job_diff) << 14) + (NW'(job_diff) << 13) + (NW'(job_diff) << 10);

	assign trial     = {rem_q, lo_q[SCORE_W-1]};
	assign trial_sub = trial - {1'b0, mag_q};
	assign take      = (trial >= {1'b0, mag_q});
	assign quo_next  = {quo_q[SCORE_W-2:0], take};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BS_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BS_CHECK;
				end
			end
			BS_CHECK: begin
				if (miss_q || (mag_q == '0) || ({1'b0, hi_q} >= mag_q)) begin
					state_d = BS_EMIT;
				end else begin
					state_d = BS_DIV;
				end
			end
			BS_DIV: begin
				if (cnt_q == '0) begin
					state_d = BS_EMIT;
				end
			end
			BS_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == BS_CHECK) begin
			cnt_q <= CW'(SCORE_W - 1);
		end else if (state_q == BS_DIV) begin
			cnt_q <= CW'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_IDLE: begin
				hi_q   <= num_c[NW-1:SCORE_W];
				lo_q   <= num_c[SCORE_W-1:0];
				mag_q  <= job_mag;
				miss_q <= job_missing;
			end
			BS_CHECK: begin
				rem_q      <= ACC_W'(hi_q);
				quo_q      <= '0;
				res_miss_q <= miss_q;
				if (miss_q) begin
					res_score_q <= '0;
				end else if (mag_q == '0) begin
					res_score_q <= worst_score;
				end else begin
					res_score_q <= SCORE_CAP;
				end
			end
			BS_DIV: begin
				rem_q <= take ? trial_sub[ACC_W-1:0] : trial[ACC_W-1:0];
				lo_q  <= {lo_q[SCORE_W-2:0], 1'b0};
				quo_q <= quo_next;
				if (cnt_q == '0) begin
					res_score_q <= (quo_next > SCORE_CAP) ? SCORE_CAP : quo_next;
				end
			end
			BS_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.score         <= res_score_q;
			out_data_q.score_missing <= res_miss_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`S1GS_ASSERT_HOLDS(a_div_nonzero_divisor, clk, arst_n, state_q == BS_DIV, mag_q != '0)
	`S1GS_ASSERT_HOLDS(a_div_rem_below_divisor, clk, arst_n, state_q == BS_DIV, rem_q < mag_q)
	`S1GS_ASSERT_NEXT(a_emit_completes, clk, arst_n, out_load, (state_q == BS_IDLE) && out_valid_q)
	`S1GS_ASSERT_HOLDS(a_missing_zero_score, clk, arst_n, out_valid_q && out_data_q.score_missing, out_data_q.score == '0)

endmodule

`default_nettype wire

FILE: tb/s1_gradient_score_test.sv
`timescale 1ns / 1ps

module s1_gradient_score_test;
	import s1gs_pkg::*;

	localparam int          MAX_PAIRS     = 4096;
	localparam int          SAMPLE_BITS   = 16;
	localparam longint      DIFF_LIMIT    = longint'(MAX_PAIRS) * ((64'd1 << SAMPLE_BITS) - 1);
	localparam longint      MAG_LIMIT     = longint'(MAX_PAIRS) * (64'd1 << (SAMPLE_BITS - 1));
	localparam longint      PCT_X256      = 25600;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          STALL_LIMIT   = 2000;
	localparam int          RANDOM_PAIRS  = 520;
	localparam int          BURST_PAIRS   = 150;
	localparam int          LONG_PAIRS    = 150;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	s1_gradient_score u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// predicted block state and register copies
	logic                  cfg_check_nans  = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_worst_score = WORST_SCORE_RESET;
	longint                field_diff_sum  = 0;
	longint                field_mag_sum   = 0;
	logic                  field_saw_missing = 1'b0;
	out_item_t             score_q[$];

	int errors          = 0;
	int pairs_sent      = 0;
	int fields_done     = 0;
	int missing_results = 0;
	int worst_results   = 0;
	int checked_results = 0;
	int stall_pct       = 0;
	int quiet_cycles    = 0;
	bit idle_allowed    = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sample_mag(input logic signed [15:0] v);
		return (v < 0) ? -longint'(v) : longint'(v);
	endfunction

	function automatic in_item_t mk_pair(input int rv, input int ev, input logic rm,
			input logic em, input logic last);
		in_item_t p;
		p.ref_value    = 16'(rv);
		p.eval_value   = 16'(ev);
		p.ref_missing  = rm;
		p.eval_missing = em;
		p.last_pair    = last;
		return p;
	endfunction

	task automatic predict_pair(input in_item_t p);
		longint    ra;
		longint    ea;
		longint    q;
		out_item_t res;
		if (p.ref_missing || p.eval_missing) begin
			if (!cfg_check_nans)
				field_saw_missing = 1'b1;
		end else begin
			ra = sample_mag(p.ref_value);
			ea = sample_mag(p.eval_value);
			q  = longint'(p.ref_value) - longint'(p.eval_value);
			field_diff_sum += (q < 0) ? -q : q;
			field_mag_sum  += (ra > ea) ? ra : ea;
			if (field_diff_sum > DIFF_LIMIT)
				field_diff_sum = DIFF_LIMIT;
			if (field_mag_sum > MAG_LIMIT)
				field_mag_sum = MAG_LIMIT;
		end
		if (p.last_pair) begin
			res = '0;
			if (field_saw_missing) begin
				res.score_missing = 1'b1;
				missing_results++;
			end else if (field_mag_sum == 0) begin
				res.score = cfg_worst_score;
				worst_results++;
			end else begin
				q = (field_diff_sum * PCT_X256) / field_mag_sum;
				if (q > longint'(SCORE_CAP))
					q = longint'(SCORE_CAP);
				res.score = SCORE_W'(q);
			end
			score_q.push_back(res);
			field_diff_sum    = 0;
			field_mag_sum     = 0;
			field_saw_missing = 1'b0;
			fields_done++;
		end
	endtask

	task automatic send_pair(input in_item_t p);
		if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
		predict_pair(p);
		pairs_sent++;
	endtask

	// sender holds off until every pending score has been taken, then lets the back end go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (score_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_CHECK_NANS)
			cfg_check_nans = data[0];
		else
			cfg_worst_score = data;
	endtask

	function automatic int rand_sample();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(0, 20)) - 10;
			3: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic test_extremes();
		stall_pct = 30;
		send_pair(mk_pair(32767, -32768, 1'b0, 1'b0, 1'b0));
		send_pair(mk_pair(-32768, 32767, 1'b0, 1'b0, 1'b0));
		send_pair(mk_pair(-32768, -32768, 1'b0, 1'b0, 1'b0));
		send_pair(mk_pair(32767, 32767, 1'b0, 1'b0, 1'b1));
		send_pair(mk_pair(100, 50, 1'b0, 1'b0, 1'b1));
		send_pair(mk_pair(-1, 1, 1'b0, 1'b0, 1'b1));
		send_pair(mk_pair(0, 0, 1'b0, 1'b0, 1'b1));
	endtask

	task automatic test_missing_pairs();
		write_reg(REG_CHECK_NANS, 16'd0);
		send_pair(mk_pair(5, 3, 1'b1, 1'b0, 1'b0));
		send_pair(mk_pair(10, 10, 1'b0, 1'b0, 1'b1));
		send_pair(mk_pair(7, -7, 1'b0, 1'b0, 1'b0));
		send_pair(mk_pair(-32768, 32767, 1'b0, 1'b1, 1'b1));
		write_reg(REG_CHECK_NANS, 16'd1);
		send_pair(mk_pair(-32768, 32767, 1'b1, 1'b1, 1'b0));
		send_pair(mk_pair(200, 100, 1'b0, 1'b0, 1'b1));
		send_pair(mk_pair(300, 1, 1'b0, 1'b1, 1'b1));
	endtask

	task automatic test_worst_score();
		write_reg(REG_WORST_SCORE, 16'd0);
		send_pair(mk_pair(0, 0, 1'b0, 1'b0, 1'b1));
		write_reg(REG_WORST_SCORE, SCORE_CAP);
		send_pair(mk_pair(0, 0, 1'b0, 1'b0, 1'b0));
		send_pair(mk_pair(0, 0, 1'b0, 1'b0, 1'b1));
		write_reg(REG_WORST_SCORE, 16'd1);
		send_pair(mk_pair(0, 0, 1'b0, 1'b0, 1'b1));
	endtask

	// long fields of extreme samples, large sums through the divider
	task automatic test_long_fields();
		stall_pct = 2;
		for (int i = 0; i < LONG_PAIRS; i++)
			send_pair(mk_pair(-32768, (i % 3 == 0) ? 32767 : -32768, 1'b0, 1'b0,
				i == LONG_PAIRS - 1));
		for (int i = 0; i < LONG_PAIRS; i++)
			send_pair(mk_pair(32767 - i, -i, 1'b0, 1'b0, i == LONG_PAIRS - 1));
	endtask

	task automatic run_fields(input int n_pairs);
		int stop_at;
		int len;
		int miss_pct;
		stop_at = pairs_sent + n_pairs;
		while (pairs_sent < stop_at) begin
			if (stall_pct != 0 || idle_allowed) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			len      = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
			miss_pct = ($urandom_range(0, 5) == 0) ? 40 : 4;
			for (int i = 0; i < len; i++)
				send_pair(mk_pair(rand_sample(), rand_sample(),
					$urandom_range(0, 99) < miss_pct, $urandom_range(0, 99) < miss_pct,
					i == len - 1));
		end
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			if ($urandom_range(0, 1))
				write_reg(REG_CHECK_NANS, 16'($urandom_range(0, 1)));
			case ($urandom_range(0, 3))
				0: write_reg(REG_WORST_SCORE, 16'd0);
				1: write_reg(REG_WORST_SCORE, SCORE_CAP);
				default: write_reg(REG_WORST_SCORE, 16'($urandom_range(0, 51200)));
			endcase
			run_fields(RANDOM_PAIRS / 8);
		end
	endtask

	task automatic test_back_to_back();
		idle_allowed = 1'b0;
		stall_pct    = 0;
		write_reg(REG_CHECK_NANS, 16'd1);
		run_fields(BURST_PAIRS);
	endtask

	// receiver stalls in bursts, each started at random with a chance of stall_pct percent
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 8) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			checked_results++;
			if (score_q.size() == 0) begin
				$error("unexpected transaction: score %0d score_missing %0b",
					out_data.score, out_data.score_missing);
				errors++;
			end else begin
				want = score_q.pop_front();
				if (out_data.score !== want.score) begin
					$error("score: expected %0d, actual %0d", want.score, out_data.score);
					errors++;
				end
				if (out_data.score_missing !== want.score_missing) begin
					$error("score_missing: expected %0b, actual %0b",
						want.score_missing, out_data.score_missing);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d scores pending",
				STALL_LIMIT, score_q.size());
			$display("FAIL s1_gradient_score");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_missing_pairs();
		test_worst_score();
		test_long_fields();
		test_random();
		test_back_to_back();
		settle();
		$display("covered %0d sample pairs in %0d fields, %0d scores checked",
			pairs_sent, fields_done, checked_results);
		$display("  incl. %0d missing results, %0d worst-score results, long extreme fields",
			missing_results, worst_results);
		if (errors == 0 && score_q.size() == 0) begin
			$display("PASS s1_gradient_score");
		end else begin
			$display("FAIL s1_gradient_score");
		end
		$finish;
	end

endmodule

FILE: s1_gradient_score.f
+incdir+rtl
rtl/s1gs_pkg.sv
rtl/s1gs_front.sv
rtl/s1gs_fifo.sv
rtl/s1gs_back.sv
rtl/s1_gradient_score.sv
tb/s1_gradient_score_test.sv
